/* design/mhe_pkg.sv */
package mhe_pkg;

  localparam int HEAP_DEPTH_DEF = 1024;
  localparam int DATA_W         = 32;
  localparam int LEFT_W         = 11;
  localparam int STATUS_W       = 2;

  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_EXTRACT = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic                     mode;
    logic signed [DATA_W-1:0] value;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [STATUS_W-1:0]      status;
    logic [LEFT_W-1:0]        entries_left;
  } out_t;

endpackage

/* design/mhe_ram.sv */
module mhe_ram #(
  parameter int DEPTH = mhe_pkg::HEAP_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mhe_pkg::DATA_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [mhe_pkg::DATA_W-1:0] rdata
);

  logic [mhe_pkg::DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* design/max_heap_extract.sv */
// Binary max-heap held in one synchronous RAM, level-order layout.
// Input channel: in_data (mode, value) is taken at a rising edge where start
// is high and busy is low. A load appends value at the heap end; the caller
// loads values in heap order, no sift-up is done. A load into a full heap is
// dropped with status full. An extract returns the root, moves the last entry
// to the root and sifts it down; on an empty heap it returns 0, status empty.
// Result channel: out_data is valid for exactly one cycle with out_valid high;
// the receiver cannot stall, so every result must be taken in that cycle.
// A load or an empty extract gives its result in the cycle after the
// transfer and leaves busy low, so one can be sent every cycle.
// An extract keeps busy high through the setup states (root read, last entry
// read, setup), then a child-read state and a decide state per level walked
// (one RAM read of each child; the RAM has a single read port), plus at most
// one final write state. The result is shown in the first cycle with busy low again.
// Reset empties the heap; RAM contents are not cleared, entries beyond the
// count are never used.
module max_heap_extract #(
  parameter int HEAP_DEPTH = mhe_pkg::HEAP_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  mhe_pkg::in_t  in_data,
  output logic          out_valid,
  output mhe_pkg::out_t out_data
);

  localparam int AW    = $clog2(HEAP_DEPTH);
  localparam int CNT_W = $clog2(HEAP_DEPTH + 1);
  localparam int IW    = AW + 2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ROOT,
    S_LAST,
    S_SETUP,
    S_RDR,
    S_DECIDE,
    S_WRCUR
  } state_t;

  state_t                           state_r;
  logic [CNT_W-1:0]                 count_r;
  logic [AW-1:0]                    pos_r;
  logic signed [mhe_pkg::DATA_W-1:0] root_r;
  logic signed [mhe_pkg::DATA_W-1:0] cur_r;
  logic signed [mhe_pkg::DATA_W-1:0] lval_r;
  logic                             has_r_r;
  logic                             out_valid_r;
  mhe_pkg::out_t                    out_r;

  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [mhe_pkg::DATA_W-1:0] mem_wdata;
  logic [AW-1:0]                    mem_raddr;
  logic signed [mhe_pkg::DATA_W-1:0] mem_rdata;

  logic [IW-1:0]                    lc;
  logic [IW-1:0]                    rc;
  logic [IW-1:0]                    cnt_ext;
  logic                             full;
  logic                             l_gt;
  logic                             r_gt;
  logic                             moved;
  logic signed [mhe_pkg::DATA_W-1:0] lr_val;
  logic [IW-1:0]                    lr_idx;
  logic signed [mhe_pkg::DATA_W-1:0] best_val;
  logic [IW-1:0]                    best_idx;
  logic [IW-1:0]                    new_lc;

  mhe_ram #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // child selection: right wins only if strictly greater than the winner so far
  always_comb begin
    lc       = IW'({pos_r, 1'b1});
    rc       = lc + IW'(1);
    cnt_ext  = IW'(count_r);
    full     = (count_r >= CNT_W'(HEAP_DEPTH));
    l_gt     = (lval_r > cur_r);
    lr_val   = l_gt ? lval_r : cur_r;
    lr_idx   = l_gt ? lc : IW'(pos_r);
    r_gt     = has_r_r && (mem_rdata > lr_val);
    best_val = r_gt ? mem_rdata : lr_val;
    best_idx = r_gt ? rc : lr_idx;
    moved    = l_gt || r_gt;
    new_lc   = IW'({best_idx[AW-1:0], 1'b1});
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pos_r;
    mem_wdata = cur_r;
    mem_raddr = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start && (in_data.mode == mhe_pkg::MODE_LOAD) && !full) begin
          mem_we    = 1'b1;
          mem_waddr = count_r[AW-1:0];
          mem_wdata = in_data.value;
        end
      end
      S_ROOT: begin
        mem_raddr = '0;
      end
      S_LAST: begin
        mem_raddr = count_r[AW-1:0];
      end
      S_SETUP: begin
        mem_raddr = AW'(1);
        if (count_r == CNT_W'(1)) begin
          mem_we    = 1'b1;
          mem_waddr = '0;
          mem_wdata = mem_rdata;
        end
      end
      S_RDR: begin
        mem_raddr = rc[AW-1:0];
      end
      S_DECIDE: begin
        mem_we    = 1'b1;
        mem_wdata = moved ? best_val : cur_r;
        mem_raddr = new_lc[AW-1:0];
      end
      S_WRCUR: begin
        mem_we = 1'b1;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_data.mode == mhe_pkg::MODE_LOAD) begin
              out_valid_r        <= 1'b1;
              out_r.result_value <= '0;
              if (full) begin
                out_r.status       <= mhe_pkg::ST_FULL;
                out_r.entries_left <= mhe_pkg::LEFT_W'(count_r);
              end else begin
                count_r            <= count_r + CNT_W'(1);
                out_r.status       <= mhe_pkg::ST_OK;
                out_r.entries_left <= mhe_pkg::LEFT_W'(count_r + CNT_W'(1));
              end
            end else if (count_r == '0) begin
              out_valid_r        <= 1'b1;
              out_r.result_value <= '0;
              out_r.status       <= mhe_pkg::ST_EMPTY;
              out_r.entries_left <= '0;
            end else begin
              count_r <= count_r - CNT_W'(1);
              state_r <= S_ROOT;
            end
          end
        end
        S_ROOT: begin
          state_r <= S_LAST;
        end
        S_LAST: begin
          root_r  <= mem_rdata;
          state_r <= S_SETUP;
        end
        S_SETUP: begin
          cur_r <= mem_rdata;
          pos_r <= '0;
          if (count_r <= CNT_W'(1)) begin
            out_valid_r        <= 1'b1;
            out_r.result_value <= root_r;
            out_r.status       <= mhe_pkg::ST_OK;
            out_r.entries_left <= mhe_pkg::LEFT_W'(count_r);
            state_r            <= S_IDLE;
          end else begin
            state_r <= S_RDR;
          end
        end
        S_RDR: begin
          lval_r  <= mem_rdata;
          has_r_r <= (rc < cnt_ext);
          state_r <= S_DECIDE;
        end
        S_DECIDE: begin
          if (!moved) begin
            out_valid_r        <= 1'b1;
            out_r.result_value <= root_r;
            out_r.status       <= mhe_pkg::ST_OK;
            out_r.entries_left <= mhe_pkg::LEFT_W'(count_r);
            state_r            <= S_IDLE;
          end else begin
            pos_r <= best_idx[AW-1:0];
            if (new_lc < cnt_ext) begin
              state_r <= S_RDR;
            end else begin
              state_r <= S_WRCUR;
            end
          end
        end
        S_WRCUR: begin
          out_valid_r        <= 1'b1;
          out_r.result_value <= root_r;
          out_r.status       <= mhe_pkg::ST_OK;
          out_r.entries_left <= mhe_pkg::LEFT_W'(count_r);
          state_r            <= S_IDLE;
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(HEAP_DEPTH))
    else $error("entry count above heap depth");

  a_empty_extract: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode == mhe_pkg::MODE_EXTRACT) && (count_r == '0))
    |=> (out_valid && (out_data.status == mhe_pkg::ST_EMPTY)))
    else $error("extract on empty heap did not report empty");

  a_load_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_data.mode == mhe_pkg::MODE_LOAD) && !full)
    |=> (out_valid && (out_data.status == mhe_pkg::ST_OK)))
    else $error("load transfer did not complete");

  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result shown while still busy");

endmodule

/* tb/max_heap_extract_checker.sv */
module max_heap_extract_checker #(
  parameter int DEPTH = mhe_pkg::HEAP_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          busy,
  input  mhe_pkg::in_t  in_data,
  input  logic          out_valid,
  input  mhe_pkg::out_t out_data,
  output int            mismatches,
  output int            pending
);
  import mhe_pkg::*;

  logic signed [DATA_W-1:0] heap_mirror [DEPTH];
  int                       mirror_size = 0;
  out_t                     expected_results [$];
  int                       err_count = 0;
  int                       queued = 0;

  assign mismatches = err_count;
  assign pending    = queued;

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_count++;
  endtask

  // applies one item to the mirrored heap and returns the result it causes
  function automatic out_t heap_step(input in_t item);
    out_t                     res;
    int                       pos;
    int                       best;
    int                       lc;
    int                       rc;
    bit                       settled;
    logic signed [DATA_W-1:0] tmp;
    res = '0;
    res.status = ST_OK;
    if (item.mode == MODE_LOAD) begin
      if (mirror_size >= DEPTH) begin
        res.status = ST_FULL;
      end else begin
        heap_mirror[mirror_size] = item.value;
        mirror_size++;
      end
    end else if (mirror_size == 0) begin
      res.status = ST_EMPTY;
    end else begin
      res.result_value = heap_mirror[0];
      mirror_size--;
      if (mirror_size > 0) begin
        heap_mirror[0] = heap_mirror[mirror_size];
        pos = 0;
        settled = 1'b0;
        // sift down: right child wins only when strictly greater
        while (!settled) begin
          best = pos;
          lc = 2 * pos + 1;
          rc = 2 * pos + 2;
          if (lc < mirror_size && heap_mirror[lc] > heap_mirror[best]) best = lc;
          if (rc < mirror_size && heap_mirror[rc] > heap_mirror[best]) best = rc;
          if (best == pos) begin
            settled = 1'b1;
          end else begin
            tmp = heap_mirror[pos];
            heap_mirror[pos] = heap_mirror[best];
            heap_mirror[best] = tmp;
            pos = best;
          end
        end
      end
    end
    res.entries_left = LEFT_W'(mirror_size);
    return res;
  endfunction

  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      expected_results.delete();
      mirror_size = 0;
    end else begin
      if (out_valid) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: value %0d status %0d left %0d",
                                    out_data.result_value, out_data.status,
                                    out_data.entries_left));
        end else begin
          want = expected_results.pop_front();
          if (out_data.result_value !== want.result_value)
            report_mismatch($sformatf("result_value %0d, expected %0d",
                                      out_data.result_value, want.result_value));
          if (out_data.status !== want.status)
            report_mismatch($sformatf("status %0d, expected %0d",
                                      out_data.status, want.status));
          if (out_data.entries_left !== want.entries_left)
            report_mismatch($sformatf("entries_left %0d, expected %0d",
                                      out_data.entries_left, want.entries_left));
        end
      end
      if (start && !busy) expected_results.push_back(heap_step(in_data));
    end
    queued = expected_results.size();
  end

endmodule

/* tb/max_heap_extract_tb.sv */
module max_heap_extract_tb;
  import mhe_pkg::*;

  localparam int DEPTH        = HEAP_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 850;
  localparam int CYCLE_LIMIT  = 1000000;

  logic  clk = 1'b0;
  logic  rst_n = 1'b0;
  logic  start = 1'b0;
  logic  busy;
  in_t   in_data = '0;
  logic  out_valid;
  out_t  out_data;
  int    mismatches;
  int    pending;

  int    cycles = 0;
  int    sent = 0;
  int    held = 0;
  bit    no_gaps = 1'b0;
  logic signed [DATA_W-1:0] staged [DEPTH];

  max_heap_extract #(.HEAP_DEPTH(DEPTH)) uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  max_heap_extract_checker #(.DEPTH(DEPTH)) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_data   (out_data),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAIL max_heap_extract");
      $finish;
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      1: return DATA_W'(int'($urandom_range(0, 8)) - 4);
      2: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return 32'sh0000_0000;
          default: return 32'shffff_ffff;
        endcase
      end
      default: return $urandom;
    endcase
  endfunction

  // one transfer, returns right after the accepting edge
  task automatic transfer_item(input logic mode, input logic signed [DATA_W-1:0] value);
    int gap;
    gap = gap_len();
    @(negedge clk);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    in_data.mode <= mode;
    in_data.value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    sent++;
    if (mode == MODE_LOAD) begin
      if (held < DEPTH) held++;
    end else if (held > 0) begin
      held--;
    end
  endtask

  task automatic hold_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic drain_heap(input bit one_extra);
    int n;
    n = held + (one_extra ? 1 : 0);
    repeat (n) transfer_item(MODE_EXTRACT, $urandom);
  endtask

  // builds a valid heap by sift-up, then loads it in level order
  task automatic load_valid_heap(input int n);
    int                       j;
    logic signed [DATA_W-1:0] tmp;
    for (int i = 0; i < n; i++) begin
      staged[i] = pick_value();
      j = i;
      while (j > 0 && staged[(j - 1) / 2] < staged[j]) begin
        tmp = staged[j];
        staged[j] = staged[(j - 1) / 2];
        staged[(j - 1) / 2] = tmp;
        j = (j - 1) / 2;
      end
    end
    for (int i = 0; i < n; i++) transfer_item(MODE_LOAD, staged[i]);
  endtask

  initial begin
    int base;
    int n;
    int k;
    int r;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty extract, extremes and ties, out-of-order loads
    no_gaps = 1'b1;
    transfer_item(MODE_EXTRACT, 32'sh1234_5678);
    transfer_item(MODE_LOAD, 32'sh7fff_ffff);
    transfer_item(MODE_LOAD, 32'sd5);
    transfer_item(MODE_LOAD, 32'sd5);
    transfer_item(MODE_LOAD, 32'sh8000_0000);
    transfer_item(MODE_LOAD, 32'shffff_ffff);
    transfer_item(MODE_LOAD, 32'sd0);
    repeat (6) transfer_item(MODE_EXTRACT, 32'shffff_ffff);
    transfer_item(MODE_EXTRACT, 32'sh0);
    transfer_item(MODE_LOAD, -32'sd7);
    transfer_item(MODE_LOAD, 32'sd9);
    transfer_item(MODE_LOAD, 32'sd3);
    repeat (4) transfer_item(MODE_EXTRACT, $urandom);
    no_gaps = 1'b0;
    hold_until_drained();

    base = sent;
    while (sent - base < RANDOM_ITEMS) begin
      no_gaps = ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 9);
      if (r < 7) begin
        drain_heap($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
        load_valid_heap(n);
        k = ($urandom_range(0, 1) == 0) ? $urandom_range(0, n) : n + $urandom_range(0, 1);
        repeat (k) transfer_item(MODE_EXTRACT, $urandom);
      end else if (r < 9) begin
        // noise: arbitrary modes and out-of-order loads
        repeat ($urandom_range(1, 10)) transfer_item(logic'($urandom_range(0, 1)), pick_value());
      end else begin
        hold_until_drained();
      end
    end

    // fill to capacity, overflow, then deep extracts
    no_gaps = 1'b0;
    drain_heap(1'b0);
    load_valid_heap(DEPTH);
    repeat (3) transfer_item(MODE_LOAD, pick_value());
    repeat (40) transfer_item(MODE_EXTRACT, $urandom);

    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (mismatches == 0) begin
      $display("PASS max_heap_extract");
    end else begin
      $display("FAIL max_heap_extract");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/mhe_pkg.sv
design/mhe_ram.sv
design/max_heap_extract.sv
tb/max_heap_extract_checker.sv
tb/max_heap_extract_tb.sv
